// File: hdl/hms_clock_countdown_alarm_top_assert.svh
// Assertion macros for the hms clock/countdown block checker.
// Included by the checker file only; no other dependencies.
`ifndef HMS_CLOCK_COUNTDOWN_ALARM_TOP_ASSERT_SVH
`define HMS_CLOCK_COUNTDOWN_ALARM_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HMSCA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HMSCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/hmsca_pkg.sv
// Shared types and constants for the hms clock/countdown/alarm block.
// No dependencies; used by the interfaces and all modules.
package hmsca_pkg;

	localparam int HOUR_W     = 5;
	localparam int MIN_W      = 6;
	localparam int SEC_W      = 6;
	localparam int MODE_W     = 2;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;

	localparam logic [HOUR_W-1:0] HOURS_PER_DAY    = 5'd24;
	localparam logic [HOUR_W-1:0] LAST_HOUR        = 5'd23;
	localparam logic [HOUR_W-1:0] HALF_DAY         = 5'd12;
	localparam logic [MIN_W-1:0]  MINUTES_PER_HOUR = 6'd60;
	localparam logic [MIN_W-1:0]  LAST_MINUTE      = 6'd59;
	localparam logic [SEC_W-1:0]  SECS_PER_MINUTE  = 6'd60;
	localparam logic [SEC_W-1:0]  LAST_SECOND      = 6'd59;

	typedef enum logic [OP_W-1:0] {
		OP_FORWARD  = 2'd0,
		OP_BACKWARD = 2'd1,
		OP_LOAD     = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_TIME      = 2'd0,
		MODE_COUNTDOWN = 2'd1,
		MODE_PLAIN     = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLOCK_MODE    = 3'd0,
		REG_ALARM_HOUR    = 3'd1,
		REG_ALARM_MINUTE  = 3'd2,
		REG_ALARM_SECOND  = 3'd3,
		REG_TWELVE_HOUR   = 3'd4,
		REG_SHOW_MERIDIEM = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [SEC_W-1:0]  second;
	} hms_t;

	typedef struct packed {
		logic [MODE_W-1:0] clock_mode;
		hms_t              alarm;
		logic              twelve_hour;
		logic              show_meridiem;
	} cfg_t;

	typedef struct packed {
		logic alarm_hit;
		logic day_rollover;
		logic time_changed;
	} flags_t;

	typedef struct packed {
		hms_t              now;
		logic [HOUR_W-1:0] display_hour;
		logic              pm_flag;
		flags_t            flags;
	} result_t;

endpackage

// File: hdl/hmsca_if.sv
// Valid/ready channel interfaces: input items, results and register writes.
// Depends on hmsca_pkg for field widths.
interface hmsca_item_if;
	import hmsca_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [HOUR_W-1:0] load_hour;
	logic [MIN_W-1:0]  load_minute;
	logic [SEC_W-1:0]  load_second;
	modport source (output valid, operation, load_hour, load_minute, load_second,
		input ready);
	modport sink (input valid, operation, load_hour, load_minute, load_second,
		output ready);
endinterface

interface hmsca_result_if;
	import hmsca_pkg::*;
	logic              valid;
	logic              ready;
	logic [HOUR_W-1:0] hour_now;
	logic [MIN_W-1:0]  minute_now;
	logic [SEC_W-1:0]  second_now;
	logic [HOUR_W-1:0] display_hour;
	logic              pm_flag;
	logic              alarm_hit;
	logic              day_rollover;
	logic              time_changed;
	modport source (output valid, hour_now, minute_now, second_now, display_hour,
		pm_flag, alarm_hit, day_rollover, time_changed, input ready);
	modport sink (input valid, hour_now, minute_now, second_now, display_hour,
		pm_flag, alarm_hit, day_rollover, time_changed, output ready);
endinterface

interface hmsca_cfg_if;
	import hmsca_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/hmsca_step.sv
// Next-time and event logic for one item: tick up/down with carry, load, flags.
// Depends on hmsca_pkg.
module hmsca_step (
	input  hmsca_pkg::cfg_t            cfg_regs,
	input  hmsca_pkg::hms_t            cur,
	input  logic [hmsca_pkg::OP_W-1:0] operation,
	input  hmsca_pkg::hms_t            load,
	output hmsca_pkg::result_t         res
);
	import hmsca_pkg::*;

	hms_t   up;
	hms_t   dn;
	hms_t   nxt;
	flags_t flags;
	logic   wrapped;
	logic   at_zero;
	logic   cd_hit;
	logic   countdown;
	logic   time_mode;
	logic   s_last;
	logic   m_last;

	always_comb begin
		countdown = 1'b0;
		time_mode = 1'b0;
		unique case (cfg_regs.clock_mode)
			MODE_COUNTDOWN: countdown = 1'b1;
			MODE_PLAIN:     ;
			default:        time_mode = 1'b1;
		endcase

		// count up with carries
		s_last    = (cur.second == LAST_SECOND);
		m_last    = (cur.minute == LAST_MINUTE);
		up.second = s_last ? '0 : cur.second + SEC_W'(1);
		up.minute = !s_last ? cur.minute : (m_last ? '0 : cur.minute + MIN_W'(1));
		up.hour   = !(s_last && m_last) ? cur.hour :
			((cur.hour == LAST_HOUR) ? '0 : cur.hour + HOUR_W'(1));
		wrapped   = s_last && m_last && (cur.hour == LAST_HOUR);

		// count down with borrows, 00:00:00 wraps to 23:59:59
		dn.second = (cur.second != '0) ? cur.second - SEC_W'(1) : LAST_SECOND;
		dn.minute = (cur.second != '0) ? cur.minute :
			((cur.minute != '0) ? cur.minute - MIN_W'(1) : LAST_MINUTE);
		dn.hour   = (cur.second != '0 || cur.minute != '0) ? cur.hour :
			((cur.hour != '0) ? cur.hour - HOUR_W'(1) : LAST_HOUR);

		at_zero = (cur.hour == '0) && (cur.minute == '0) && (cur.second == '0);
		cd_hit  = (cur.hour == '0) && (cur.minute == '0) && (cur.second == SEC_W'(1));

		nxt   = cur;
		flags = '{alarm_hit: 1'b0, day_rollover: 1'b0, time_changed: 1'b1};
		unique case (op_t'(operation))
			OP_FORWARD: begin
				if (countdown) begin
					if (at_zero) begin
						flags.time_changed = 1'b0;
					end else begin
						nxt             = dn;
						flags.alarm_hit = cd_hit;
					end
				end else begin
					nxt = up;
					if (time_mode) begin
						flags.day_rollover = wrapped;
						flags.alarm_hit    = (up == cfg_regs.alarm);
					end
				end
			end
			OP_BACKWARD: nxt = countdown ? up : dn;
			OP_LOAD: begin
				nxt.hour   = (load.hour < HOURS_PER_DAY) ? load.hour : '0;
				nxt.minute = (load.minute < MINUTES_PER_HOUR) ? load.minute : '0;
				nxt.second = (load.second < SECS_PER_MINUTE) ? load.second : '0;
			end
			OP_NONE: flags.time_changed = 1'b0;
		endcase

		res.now          = nxt;
		res.display_hour = (cfg_regs.twelve_hour && nxt.hour > HALF_DAY) ?
			nxt.hour - HALF_DAY : nxt.hour;
		res.pm_flag      = cfg_regs.twelve_hour && cfg_regs.show_meridiem &&
			(nxt.hour >= HALF_DAY);
		res.flags        = flags;
	end

endmodule

// File: hdl/hms_clock_countdown_alarm_top.sv
// Top level of the hms clock with alarm and countdown.
// Depends on hmsca_pkg, the hmsca_*_if interfaces and hmsca_step.
//
// Usage:
//   item   : valid/ready channel of ticks and time loads (operation + load fields).
//   result : valid/ready channel, one result transaction per item, in order.
//   cfg    : register write channel (index, data); always ready. Write only
//            while no item is in flight. Unknown indexes are dropped.
// Pipeline: an accepted item goes through the input register, then the result
//   register. Throughput: one item per cycle while result.ready is high.
// Reset (arst_n low): time is 00:00:00, config registers 0, both stages empty.
// Back-pressure: while a result waits for ready, one more item is still taken
//   into the input register; after that item.ready drops until result.ready.
module hms_clock_countdown_alarm_top (
	input  logic           clk,
	input  logic           arst_n,
	hmsca_item_if.sink     item,
	hmsca_result_if.source result,
	hmsca_cfg_if.sink      cfg
);
	import hmsca_pkg::*;

	cfg_t            cfg_q;
	hms_t            time_q;
	logic            valid_s1;
	logic [OP_W-1:0] op_s1;
	hms_t            load_s1;
	result_t         res_d;
	result_t         res_q;
	logic            res_valid_q;
	logic            advance;

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CLOCK_MODE:    cfg_q.clock_mode    <= cfg.data[MODE_W-1:0];
				REG_ALARM_HOUR:    cfg_q.alarm.hour    <= cfg.data[HOUR_W-1:0];
				REG_ALARM_MINUTE:  cfg_q.alarm.minute  <= cfg.data[MIN_W-1:0];
				REG_ALARM_SECOND:  cfg_q.alarm.second  <= cfg.data[SEC_W-1:0];
				REG_TWELVE_HOUR:   cfg_q.twelve_hour   <= cfg.data[0];
				REG_SHOW_MERIDIEM: cfg_q.show_meridiem <= cfg.data[0];
				default:           ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			op_s1    <= OP_NONE;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
			if (item.valid) begin
				op_s1 <= item.operation;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			load_s1.hour   <= item.load_hour;
			load_s1.minute <= item.load_minute;
			load_s1.second <= item.load_second;
		end
	end

	hmsca_step u_step (
		.cfg_regs  (cfg_q),
		.cur       (time_q),
		.operation (op_s1),
		.load      (load_s1),
		.res       (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				time_q <= res_d.now;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.hour_now     = res_q.now.hour;
	assign result.minute_now   = res_q.now.minute;
	assign result.second_now   = res_q.now.second;
	assign result.display_hour = res_q.display_hour;
	assign result.pm_flag      = res_q.pm_flag;
	assign result.alarm_hit    = res_q.flags.alarm_hit;
	assign result.day_rollover = res_q.flags.day_rollover;
	assign result.time_changed = res_q.flags.time_changed;

endmodule

// File: hdl/hmsca_checker.sv
// Port-level checker for the hms clock top level, attached by bind.
// Depends on hmsca_pkg and hms_clock_countdown_alarm_top_assert.svh.
`include "hms_clock_countdown_alarm_top_assert.svh"

module hmsca_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic [hmsca_pkg::HOUR_W-1:0] hour_now,
	input logic [hmsca_pkg::MIN_W-1:0]  minute_now,
	input logic [hmsca_pkg::SEC_W-1:0]  second_now,
	input logic                         pm_flag,
	input logic                         day_rollover
);
	import hmsca_pkg::*;

	`HMSCA_ASSERT_NEXT(a_result_hold, clk, arst_n,
		result_valid && !result_ready,
		result_valid && $stable(hour_now) && $stable(minute_now) && $stable(second_now),
		"result transaction changed while stalled")

	`HMSCA_ASSERT_IMPLY(a_time_range, clk, arst_n, result_valid,
		hour_now <= LAST_HOUR && minute_now <= LAST_MINUTE && second_now <= LAST_SECOND,
		"reported time out of range")

	`HMSCA_ASSERT_IMPLY(a_rollover_midnight, clk, arst_n, result_valid && day_rollover,
		hour_now == '0 && minute_now == '0 && second_now == '0,
		"day rollover reported away from midnight")

	`HMSCA_ASSERT_IMPLY(a_pm_afternoon, clk, arst_n, result_valid && pm_flag,
		hour_now >= HALF_DAY,
		"PM flag set before noon")

endmodule

bind hms_clock_countdown_alarm_top hmsca_checker u_hmsca_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.hour_now     (result.hour_now),
	.minute_now   (result.minute_now),
	.second_now   (result.second_now),
	.pm_flag      (result.pm_flag),
	.day_rollover (result.day_rollover)
);

// File: tb/testbench.sv
// Self-checking testbench for the hms clock with alarm and countdown.
// Depends on hmsca_pkg, the hmsca_*_if interfaces and hms_clock_countdown_alarm_top.
module testbench;
	import hmsca_pkg::*;

	localparam logic [MODE_W-1:0]    MODE_ALIAS_TIME = 2'd3;  // undefined mode, acts as time of day
	localparam logic [CFG_IDX_W-1:0] REG_SPARE       = 3'd6;  // no register behind it
	localparam int                   LONG_HOLD       = 64;

	typedef struct packed {
		op_t               op;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [SEC_W-1:0]  second;
	} clock_cmd_t;

	logic clk;
	logic arst_n;

	hmsca_item_if   item ();
	hmsca_result_if result ();
	hmsca_cfg_if    cfg ();

	hms_clock_countdown_alarm_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	// shadow of the block's registers and time
	logic [MODE_W-1:0] cfg_mode;
	logic [HOUR_W-1:0] cfg_alarm_h;
	logic [MIN_W-1:0]  cfg_alarm_m;
	logic [SEC_W-1:0]  cfg_alarm_s;
	logic              cfg_twelve;
	logic              cfg_meridiem;
	logic [HOUR_W-1:0] now_h;
	logic [MIN_W-1:0]  now_m;
	logic [SEC_W-1:0]  now_s;

	clock_cmd_t cmd_queue[$];
	result_t    readings_due[$];
	int         error_count;

	logic item_taken;
	int   burst_left, gap_left, burst_max, gap_max;
	int   stall_pct, hold_left;
	bit   long_hold_req;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic report_mismatch(string what, int got, int want);
		$display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// one second up with carries; events only count in time-of-day mode
	function automatic void tick_up(input bit tod, output bit alarm, output bit wrapped);
		alarm = 1'b0;
		wrapped = 1'b0;
		if (now_s == LAST_SECOND) begin
			now_s = '0;
			if (now_m == LAST_MINUTE) begin
				now_m = '0;
				if (now_h >= LAST_HOUR) begin
					now_h = '0;
					wrapped = tod;
				end else begin
					now_h++;
				end
			end else begin
				now_m++;
			end
		end else begin
			now_s++;
		end
		alarm = tod && now_h == cfg_alarm_h && now_m == cfg_alarm_m && now_s == cfg_alarm_s;
	endfunction

	// one second down with borrows; returns 0 when a countdown sits at zero
	function automatic bit tick_down(input bit countdown, output bit alarm);
		alarm = 1'b0;
		if (countdown && now_h == '0 && now_m == '0 && now_s == '0)
			return 1'b0;
		if (now_s != '0) begin
			now_s--;
			alarm = countdown && now_h == '0 && now_m == '0 && now_s == '0;
			return 1'b1;
		end
		now_s = LAST_SECOND;
		if (now_m != '0) begin
			now_m--;
			return 1'b1;
		end
		now_m = LAST_MINUTE;
		if (now_h != '0) begin
			now_h--;
			return 1'b1;
		end
		now_h = LAST_HOUR;
		return 1'b1;
	endfunction

	function automatic result_t next_clock_reading(clock_cmd_t c);
		logic [MODE_W-1:0] mode;
		bit                countdown, tod, alarm, wrapped, changed;
		result_t           r;
		mode = (cfg_mode == MODE_ALIAS_TIME) ? MODE_TIME : cfg_mode;
		countdown = (mode == MODE_COUNTDOWN);
		tod = (mode == MODE_TIME);
		alarm = 1'b0;
		wrapped = 1'b0;
		changed = 1'b1;
		case (c.op)
			OP_FORWARD: begin
				if (countdown)
					changed = tick_down(1'b1, alarm);
				else
					tick_up(tod, alarm, wrapped);
			end
			OP_BACKWARD: begin
				if (countdown)
					tick_up(1'b0, alarm, wrapped);
				else
					changed = tick_down(1'b0, alarm);
			end
			OP_LOAD: begin
				now_h = (c.hour < HOURS_PER_DAY) ? c.hour : '0;
				now_m = (c.minute < MINUTES_PER_HOUR) ? c.minute : '0;
				now_s = (c.second < SECS_PER_MINUTE) ? c.second : '0;
			end
			default: changed = 1'b0;
		endcase
		r.now.hour = now_h;
		r.now.minute = now_m;
		r.now.second = now_s;
		r.display_hour = (cfg_twelve && now_h > HALF_DAY) ? now_h - HALF_DAY : now_h;
		r.pm_flag = cfg_twelve && cfg_meridiem && now_h >= HALF_DAY;
		r.flags.alarm_hit = alarm;
		r.flags.day_rollover = wrapped;
		r.flags.time_changed = changed;
		return r;
	endfunction

	// driver: bursts of transactions separated by random gaps
	always @(negedge clk) begin : item_driver
		clock_cmd_t c;
		if (arst_n) begin
			if (item.valid && !item_taken) begin
				// hold the offered transaction
			end else if (gap_left > 0) begin
				item.valid <= 1'b0;
				gap_left--;
			end else if (cmd_queue.size() != 0) begin
				c = cmd_queue.pop_front();
				item.valid <= 1'b1;
				item.operation <= c.op;
				item.load_hour <= c.hour;
				item.load_minute <= c.minute;
				item.load_second <= c.second;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, burst_max);
					gap_left = $urandom_range(0, gap_max);
				end
			end else begin
				item.valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (long_hold_req && hold_left == 0) begin
			hold_left = LONG_HOLD;
			long_hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// monitor and predictor
	always @(posedge clk) begin : result_monitor
		result_t    want;
		clock_cmd_t c;
		if (arst_n) begin
			item_taken <= item.valid && item.ready;
			if (result.valid && result.ready) begin
				if (readings_due.size() == 0) begin
					report_mismatch("result transaction with none pending", 1, 0);
				end else begin
					want = readings_due.pop_front();
					if (result.hour_now !== want.now.hour)
						report_mismatch("hour_now", int'(result.hour_now),
							int'(want.now.hour));
					if (result.minute_now !== want.now.minute)
						report_mismatch("minute_now", int'(result.minute_now),
							int'(want.now.minute));
					if (result.second_now !== want.now.second)
						report_mismatch("second_now", int'(result.second_now),
							int'(want.now.second));
					if (result.display_hour !== want.display_hour)
						report_mismatch("display_hour", int'(result.display_hour),
							int'(want.display_hour));
					if (result.pm_flag !== want.pm_flag)
						report_mismatch("pm_flag", int'(result.pm_flag), int'(want.pm_flag));
					if (result.alarm_hit !== want.flags.alarm_hit)
						report_mismatch("alarm_hit", int'(result.alarm_hit),
							int'(want.flags.alarm_hit));
					if (result.day_rollover !== want.flags.day_rollover)
						report_mismatch("day_rollover", int'(result.day_rollover),
							int'(want.flags.day_rollover));
					if (result.time_changed !== want.flags.time_changed)
						report_mismatch("time_changed", int'(result.time_changed),
							int'(want.flags.time_changed));
				end
			end
			if (item.valid && item.ready) begin
				c.op = op_t'(item.operation);
				c.hour = item.load_hour;
				c.minute = item.load_minute;
				c.second = item.load_second;
				readings_due.push_back(next_clock_reading(c));
			end
		end
	end

	task automatic queue_cmd(op_t op, logic [HOUR_W-1:0] h, logic [MIN_W-1:0] m,
		logic [SEC_W-1:0] s);
		clock_cmd_t c;
		c.op = op;
		c.hour = h;
		c.minute = m;
		c.second = s;
		cmd_queue.push_back(c);
	endtask

	task automatic wait_idle();
		while (cmd_queue.size() != 0 || item.valid || readings_due.size() != 0)
			@(posedge clk);
	endtask

	// bits above the register width are sometimes filled with junk
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value, int width);
		logic [CFG_DATA_W-1:0] data;
		logic [CFG_DATA_W-1:0] keep;
		keep = (CFG_DATA_W'(1) << width) - CFG_DATA_W'(1);
		data = value & keep;
		if ($urandom_range(0, 3) == 0)
			data = data | (CFG_DATA_W'($urandom) & ~keep);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_CLOCK_MODE:    cfg_mode = data[MODE_W-1:0];
			REG_ALARM_HOUR:    cfg_alarm_h = data[HOUR_W-1:0];
			REG_ALARM_MINUTE:  cfg_alarm_m = data[MIN_W-1:0];
			REG_ALARM_SECOND:  cfg_alarm_s = data[SEC_W-1:0];
			REG_TWELVE_HOUR:   cfg_twelve = data[0];
			REG_SHOW_MERIDIEM: cfg_meridiem = data[0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [MODE_W-1:0] mode, logic [HOUR_W-1:0] ah,
		logic [MIN_W-1:0] am, logic [SEC_W-1:0] as_, logic twelve, logic meridiem);
		wait_idle();
		write_reg(REG_CLOCK_MODE, CFG_DATA_W'(mode), MODE_W);
		write_reg(REG_ALARM_HOUR, CFG_DATA_W'(ah), HOUR_W);
		write_reg(REG_ALARM_MINUTE, CFG_DATA_W'(am), MIN_W);
		write_reg(REG_ALARM_SECOND, CFG_DATA_W'(as_), SEC_W);
		write_reg(REG_TWELVE_HOUR, CFG_DATA_W'(twelve), 1);
		write_reg(REG_SHOW_MERIDIEM, CFG_DATA_W'(meridiem), 1);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// load a starting time, run some ticks one way, then back the other way
	task automatic queue_random_run(output int added);
		int                kind, steps, noise;
		logic [HOUR_W-1:0] h;
		logic [MIN_W-1:0]  m;
		logic [SEC_W-1:0]  s;
		op_t               dir;
		kind = $urandom_range(0, 5);
		case (kind)
			0: begin h = cfg_alarm_h; m = cfg_alarm_m; s = cfg_alarm_s; end
			1: begin h = LAST_HOUR; m = LAST_MINUTE; s = SEC_W'($urandom_range(52, 59)); end
			2: begin
				h = HOUR_W'($urandom_range(0, 23));
				m = LAST_MINUTE;
				s = SEC_W'($urandom_range(54, 59));
			end
			3: begin h = '0; m = '0; s = SEC_W'($urandom_range(0, 5)); end
			4: begin h = HOUR_W'($urandom); m = MIN_W'($urandom); s = SEC_W'($urandom); end
			default: begin
				h = HOUR_W'($urandom_range(0, 23));
				m = MIN_W'($urandom_range(0, 59));
				s = SEC_W'($urandom_range(0, 59));
			end
		endcase
		queue_cmd(OP_LOAD, h, m, s);
		added = 1;
		steps = $urandom_range(1, 8);
		dir = $urandom_range(0, 1) ? OP_FORWARD : OP_BACKWARD;
		for (int i = 0; i < 2 * steps + 2; i++) begin
			if (i == steps)
				dir = (dir == OP_FORWARD) ? OP_BACKWARD : OP_FORWARD;
			noise = $urandom_range(0, 15);
			if (noise == 0)
				queue_cmd(op_t'(OP_W'($urandom_range(0, 3))), HOUR_W'($urandom),
					MIN_W'($urandom), SEC_W'($urandom));
			else if (noise == 1)
				queue_cmd(OP_LOAD, HOUR_W'($urandom), MIN_W'($urandom), SEC_W'($urandom));
			else
				queue_cmd(dir, HOUR_W'($urandom), MIN_W'($urandom), SEC_W'($urandom));
			added++;
		end
	endtask

	initial begin : stimulus
		int                random_items, phase_items, added;
		logic [HOUR_W-1:0] ah;
		logic [MIN_W-1:0]  am;
		logic [SEC_W-1:0]  as_;
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.operation = OP_NONE;
		item.load_hour = '0;
		item.load_minute = '0;
		item.load_second = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_CLOCK_MODE;
		cfg.data = '0;
		item_taken = 1'b0;
		error_count = 0;
		cfg_mode = MODE_TIME;
		cfg_alarm_h = '0;
		cfg_alarm_m = '0;
		cfg_alarm_s = '0;
		cfg_twelve = 1'b0;
		cfg_meridiem = 1'b0;
		now_h = '0;
		now_m = '0;
		now_s = '0;
		burst_left = 0;
		gap_left = 0;
		burst_max = 8;
		gap_max = 0;
		stall_pct = 0;
		hold_left = 0;
		long_hold_req = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// time of day: midnight wrap with alarm at 00:00:00, clamped loads, 12-hour form
		set_config(MODE_TIME, '0, '0, '0, 1'b1, 1'b1);
		queue_cmd(OP_LOAD, 5'd23, 6'd59, 6'd59);
		queue_cmd(OP_FORWARD, '0, '0, '0);
		queue_cmd(OP_BACKWARD, '0, '0, '0);
		queue_cmd(OP_LOAD, 5'd31, 6'd63, 6'd63);
		queue_cmd(OP_LOAD, 5'd24, 6'd60, 6'd60);
		queue_cmd(OP_LOAD, 5'd12, 6'd59, 6'd59);
		queue_cmd(OP_FORWARD, '0, '0, '0);
		queue_cmd(OP_NONE, 5'd31, 6'd63, 6'd63);
		queue_cmd(OP_LOAD, 5'd0, 6'd59, 6'd59);
		queue_cmd(OP_FORWARD, '0, '0, '0);
		queue_cmd(OP_LOAD, 5'd5, 6'd0, 6'd0);
		queue_cmd(OP_BACKWARD, '0, '0, '0);

		// countdown: reach zero, hold there, count back up, wrap without rollover
		set_config(MODE_COUNTDOWN, 5'd31, 6'd63, 6'd63, 1'b0, 1'b1);
		queue_cmd(OP_LOAD, 5'd0, 6'd0, 6'd2);
		queue_cmd(OP_FORWARD, '0, '0, '0);
		queue_cmd(OP_FORWARD, '0, '0, '0);
		queue_cmd(OP_FORWARD, '0, '0, '0);
		queue_cmd(OP_BACKWARD, '0, '0, '0);
		queue_cmd(OP_LOAD, 5'd0, 6'd1, 6'd0);
		queue_cmd(OP_FORWARD, '0, '0, '0);
		queue_cmd(OP_LOAD, 5'd23, 6'd59, 6'd59);
		queue_cmd(OP_BACKWARD, '0, '0, '0);

		// mode three counts as time of day; plain mode wraps silently
		set_config(MODE_ALIAS_TIME, 5'd12, 6'd0, 6'd0, 1'b1, 1'b0);
		write_reg(REG_SPARE, CFG_DATA_W'($urandom), CFG_DATA_W);
		@(negedge clk);
		cfg.valid <= 1'b0;
		queue_cmd(OP_LOAD, 5'd11, 6'd59, 6'd59);
		queue_cmd(OP_FORWARD, '0, '0, '0);
		set_config(MODE_PLAIN, 5'd0, 6'd0, 6'd0, 1'b1, 1'b1);
		queue_cmd(OP_LOAD, 5'd23, 6'd59, 6'd59);
		queue_cmd(OP_FORWARD, '0, '0, '0);

		random_items = 0;
		for (int p = 0; random_items < 700; p++) begin
			ah = ($urandom_range(0, 4) == 0) ? HOUR_W'($urandom_range(24, 31)) :
				HOUR_W'($urandom_range(0, 23));
			am = ($urandom_range(0, 4) == 0) ? MIN_W'($urandom_range(60, 63)) :
				MIN_W'($urandom_range(0, 59));
			as_ = ($urandom_range(0, 4) == 0) ? SEC_W'($urandom_range(60, 63)) :
				SEC_W'($urandom_range(0, 59));
			set_config(MODE_W'($urandom_range(0, 3)), ah, am, as_, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			case (p % 4)
				0: begin gap_max = 0; burst_max = 8; stall_pct = 0; end
				1: begin gap_max = 6; burst_max = 4; stall_pct = 60; end
				2: begin gap_max = 3; burst_max = 10; stall_pct = 25; end
				default: begin
					// receiver goes quiet while the sender keeps pushing
					gap_max = 0;
					burst_max = 16;
					stall_pct = 30;
					long_hold_req = 1'b1;
				end
			endcase
			phase_items = 0;
			while (phase_items < 90) begin
				queue_random_run(added);
				phase_items += added;
			end
			random_items += phase_items;
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (readings_due.size() != 0)
			report_mismatch("results never produced", readings_due.size(), 0);
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
